// ----- sv/sha1_message_digest_assert.svh -----
// Assertion macros for the SHA-1 message digest block.
// Used by the top level; expects clk and rst in scope at the point of use.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, off during reset.
`define SHA1MD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1md: check failed");

// Next-cycle implication, off during reset.
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1md: check failed");

`endif

// ----- sv/sha1md_pkg.sv -----
// Shared types and constants for the SHA-1 message digest block.
// No dependencies; imported by the front, the back and the top level.
`default_nettype none

package sha1md_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } sha1md_in_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } sha1md_out_t;

  // Command codes queued from front to back
  localparam logic [1:0] OP_BYTE     = 2'd0;
  localparam logic [1:0] OP_END      = 2'd1;
  localparam logic [1:0] OP_BYTE_END = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } sha1md_cmd_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Index 0 holds H0
  localparam logic [4:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_0_19  = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_POS      = 6'd56;
  localparam int         DIGEST_BYTES = 20;

endpackage

`default_nettype wire

// ----- sv/sha1md_front.sv -----
// Input side of the SHA-1 block: accept, classify and queue transactions.
// Depends on sha1md_pkg for the payload and command types.
`default_nettype none

module sha1md_front #(
  parameter int QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire sha1md_pkg::sha1md_in_t  in_data,
  output logic                     cmd_valid,
  input  wire                      cmd_ready,
  output sha1md_pkg::sha1md_cmd_t  cmd
);
  import sha1md_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sha1md_cmd_t        queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  sha1md_cmd_t        entry;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];

  // Drop items that carry neither a byte nor an end mark
  assign push = in_valid && in_ready && (in_data.has_byte || in_data.is_last);
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    entry.data = in_data.data_byte;
    if (in_data.has_byte && in_data.is_last) begin
      entry.op = OP_BYTE_END;
    end else if (in_data.has_byte) begin
      entry.op = OP_BYTE;
    end else begin
      entry.op = OP_END;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sha1md_back.sv -----
// Engine side of the SHA-1 block: block buffer, padding, 80-round compression
// and digest output register. Depends on sha1md_pkg.
`default_nettype none

module sha1md_back (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cmd_valid,
  output logic                     cmd_ready,
  input  wire sha1md_pkg::sha1md_cmd_t cmd,
  output logic                     out_valid,
  input  wire                      out_ready,
  output sha1md_pkg::sha1md_out_t  out_data
);
  import sha1md_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FINAL = 3'd2;
  localparam logic [2:0] S_PAD80 = 3'd3;
  localparam logic [2:0] S_PADZ  = 3'd4;
  localparam logic [2:0] S_LEN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [1:0] RET_IDLE  = 2'd0;
  localparam logic [1:0] RET_PAD80 = 2'd1;
  localparam logic [1:0] RET_PADZ  = 2'd2;
  localparam logic [1:0] RET_OUT   = 2'd3;

  logic [2:0]        state;
  logic [1:0]        ret;
  logic [4:0][31:0]  chain;
  logic [63:0]       byte_count;
  logic [5:0]        pos;
  logic [6:0]        t;
  logic [4:0]        ocnt;
  // Block buffer and message schedule share one line; word 15 is the oldest
  logic [15:0][31:0] win;
  logic [31:0]       a, b, c, d, e;
  logic [63:0]       len_sr;
  logic [159:0]      dig;

  logic [31:0]       w_cur;
  logic [31:0]       f;
  logic [31:0]       k;
  logic [31:0]       tmp;
  logic [31:0]       sx;
  logic [4:0][31:0]  sum;
  logic              out_free;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    sx    = win[2] ^ win[7] ^ win[13] ^ win[15];
    w_cur = (t < 7'd16) ? win[15] : {sx[30:0], sx[31]};
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_0_19;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = K_20_39;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_40_59;
    end else begin
      f = b ^ c ^ d;
      k = K_60_79;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + w_cur;
    sum[0] = chain[0] + a;
    sum[1] = chain[1] + b;
    sum[2] = chain[2] + c;
    sum[3] = chain[3] + d;
    sum[4] = chain[4] + e;
  end

  // Raise valid with each digest byte; drop it once the byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= RET_IDLE;
      chain      <= SHA1_IV;
      byte_count <= '0;
      pos        <= '0;
      t          <= '0;
      ocnt       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_BYTE, OP_BYTE_END: begin
                win        <= {win[15][23:0], win[14:0], cmd.data};
                pos        <= pos + 1'b1;
                byte_count <= byte_count + 1'b1;
                if (pos == 6'd63) begin
                  // Block full: compress, then resume or pad
                  {a, b, c, d, e} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
                  t     <= '0;
                  ret   <= (cmd.op == OP_BYTE_END) ? RET_PAD80 : RET_IDLE;
                  state <= S_ROUND;
                end else if (cmd.op == OP_BYTE_END) begin
                  state <= S_PAD80;
                end
              end
              OP_END: begin
                state <= S_PAD80;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ROUND: begin
          e   <= d;
          d   <= c;
          c   <= {b[1:0], b[31:2]};
          b   <= a;
          a   <= tmp;
          win <= {win[14:0], w_cur};
          t   <= t + 1'b1;
          if (t == 7'd79) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          case (ret)
            RET_IDLE: begin
              chain <= sum;
              state <= S_IDLE;
            end
            RET_PAD80: begin
              chain <= sum;
              state <= S_PAD80;
            end
            RET_PADZ: begin
              chain <= sum;
              state <= S_PADZ;
            end
            default: begin
              // Capture the digest and start a fresh message
              dig        <= {sum[0], sum[1], sum[2], sum[3], sum[4]};
              chain      <= SHA1_IV;
              byte_count <= '0;
              ocnt       <= '0;
              state      <= S_OUT;
            end
          endcase
        end
        S_PAD80: begin
          win <= {win[15][23:0], win[14:0], PAD_BYTE};
          pos <= pos + 1'b1;
          if (pos == 6'd63) begin
            {a, b, c, d, e} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
            t     <= '0;
            ret   <= RET_PADZ;
            state <= S_ROUND;
          end else begin
            state <= S_PADZ;
          end
        end
        S_PADZ: begin
          if (pos == LEN_POS) begin
            len_sr <= {byte_count[60:0], 3'b000};
            state  <= S_LEN;
          end else begin
            win <= {win[15][23:0], win[14:0], 8'h00};
            pos <= pos + 1'b1;
            if (pos == 6'd63) begin
              {a, b, c, d, e} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
              t     <= '0;
              ret   <= RET_PADZ;
              state <= S_ROUND;
            end
          end
        end
        S_LEN: begin
          win    <= {win[15][23:0], win[14:0], len_sr[63:56]};
          len_sr <= {len_sr[55:0], 8'h00};
          pos    <= pos + 1'b1;
          if (pos == 6'd63) begin
            {a, b, c, d, e} <= {chain[0], chain[1], chain[2], chain[3], chain[4]};
            t     <= '0;
            ret   <= RET_OUT;
            state <= S_ROUND;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data.digest_byte <= dig[159:152];
            out_data.digest_last <= (ocnt == 5'(DIGEST_BYTES - 1));
            dig                  <= {dig[151:0], 8'h00};
            ocnt                 <= ocnt + 1'b1;
            if (ocnt == 5'(DIGEST_BYTES - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/sha1_message_digest.sv -----
// SHA-1 message digest, one message byte per transaction. A transaction
// carries data_byte, has_byte and is_last; one with is_last set ends the
// message (its byte, if any, is the final one) and the block answers with
// 20 digest transactions, most significant byte of H0 first, digest_last
// high on the twentieth. A transaction with neither a byte nor is_last is
// dropped. Messages of any length are taken; the bit length wraps modulo
// 2^64. Timing: the front accepts one transaction per cycle into a short
// queue (QUEUE_DEPTH entries) and stalls only when it is full. The back
// moves one byte per cycle into the block buffer while idle, and every full
// 64-byte block then passes through the single round unit (80 rounds and
// the chaining add) before the back takes more bytes. Ending a message
// runs the padding and length steps, one or two compressions, and the
// digest output, one byte per cycle while the consumer keeps out_ready
// high. There is no clearing pass after reset. Depends on sha1md_pkg,
// sha1md_front and sha1md_back.
`default_nettype none
`include "sha1_message_digest_assert.svh"

module sha1_message_digest #(
  parameter int QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire sha1md_pkg::sha1md_in_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output sha1md_pkg::sha1md_out_t  out_data
);
  import sha1md_pkg::*;

  // Classified commands from the front queue to the engine
  logic        cmd_valid;
  logic        cmd_ready;
  sha1md_cmd_t cmd;

  // Accept and classify; hold up to QUEUE_DEPTH commands
  sha1md_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Buffer, pad, compress and drive the digest out
  sha1md_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Input stalls only when commands are waiting in a full queue
  `SHA1MD_ASSERT_NOW(a_stall_means_queued, !in_ready, cmd_valid)
  // An idle engine can only be holding the final digest byte
  `SHA1MD_ASSERT_NOW(a_idle_out_is_last, cmd_ready && out_valid, out_data.digest_last)
  // Hold a waiting digest byte, unchanged, until the consumer takes it
  `SHA1MD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for sha1_message_digest: byte stream in, 20 digest bytes out.
// Drives random and directed messages through valid/ready and checks each digest byte.
// Depends on sha1md_pkg and the sha1_message_digest RTL.
`default_nettype none

module testbench;
  import sha1md_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 64;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 320;   // padding, two compressions, digest out
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN_FLIP, RX_SPARSE} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  sha1md_in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  sha1md_out_t out_data;

  // Digest predictor state: chaining words, current 64-byte block, message length.
  logic [31:0] hash_words [5];
  logic [7:0]  block_bytes [64];
  logic [63:0] message_len_bytes;

  // Digest bytes predicted but not yet seen at the output, oldest first.
  sha1md_out_t digest_bytes_due [$];

  // Run bookkeeping.
  int unsigned error_count;
  int unsigned digest_bytes_checked;
  int unsigned message_items;
  int unsigned dropped_items;
  int unsigned messages_sent;
  int unsigned input_stall_cycles;
  int unsigned cycle_count;

  // Sender burst control and the receiver hold-off request.
  bit          sender_gaps_on;
  int unsigned burst_left;
  int unsigned stall_request;

  sha1_message_digest u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Digest predictor
  // ---------------------------------------------------------------------------

  // Run the 80-round compression on block_bytes and fold it into hash_words.
  function automatic void predict_compress();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e;
    logic [31:0] f, k, w, sum, mix;
    for (int t = 0; t < 16; t++) begin
      sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        mix = sched[(t+13) & 15] ^ sched[(t+8) & 15] ^ sched[(t+2) & 15] ^ sched[t & 15];
        w = {mix[30:0], mix[31]};
        sched[t & 15] = w;
      end else begin
        w = sched[t];
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_0_19;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_20_39;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_40_59;
      end else begin
        f = b ^ c ^ d;
        k = K_60_79;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) hash_words[i] = SHA1_IV[i];
    message_len_bytes = '0;
  endfunction

  // Absorb one accepted transaction; on the end of a message, pad, finish
  // the hash and queue the 20 digest bytes it must produce.
  function automatic void sha1_absorb(sha1md_in_t item);
    int unsigned pos;
    logic [63:0] bit_len;
    sha1md_out_t due;
    if (item.has_byte) begin
      block_bytes[message_len_bytes[5:0]] = item.data_byte;
      message_len_bytes++;
      if (message_len_bytes[5:0] == 6'd0) predict_compress();
    end
    if (!item.is_last) return;

    pos = 32'(message_len_bytes[5:0]);
    block_bytes[pos] = PAD_BYTE;
    pos++;
    // Length field no longer fits: close this block and pad a fresh one.
    if (pos > LEN_POS) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      predict_compress();
      pos = 0;
    end
    while (pos < LEN_POS) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    bit_len = message_len_bytes << 3;
    for (int i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
    predict_compress();

    for (int i = 0; i < DIGEST_BYTES; i++) begin
      due.digest_byte = hash_words[i/4][31 - 8*(i%4) -: 8];
      due.digest_last = (i == DIGEST_BYTES - 1);
      digest_bytes_due.push_back(due);
    end
    sha1_restart();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_failure(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR @%0d: %s", cycle_count, what);
  endtask

  // Compare every accepted digest transaction with the oldest prediction.
  always @(posedge clk) begin
    sha1md_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_bytes_due.size() == 0) begin
        report_failure($sformatf("digest byte %02h (last %0b) with nothing pending",
                                 out_data.digest_byte, out_data.digest_last));
      end else begin
        want = digest_bytes_due.pop_front();
        if (out_data.digest_byte !== want.digest_byte ||
            out_data.digest_last !== want.digest_last) begin
          report_failure($sformatf("digest byte exp %02h last %0b, got %02h last %0b",
                                   want.digest_byte, want.digest_last,
                                   out_data.digest_byte, out_data.digest_last));
        end
        digest_bytes_checked++;
      end
    end
  end

  // Count cycles where the block pushes back on an offered transaction.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) input_stall_cycles++;
  end

  // Watchdog: end the run if the digests never drain.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Timeout after %0d cycles, %0d digest bytes outstanding",
             CYCLE_LIMIT, digest_bytes_due.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on its own pattern, or hold off entirely on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold_left;
    int unsigned pattern_left;
    rx_pattern_t rx_pattern;
    hold_left    = 0;
    pattern_left = 0;
    rx_pattern   = RX_STEADY;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        // Hold ready low so the block backs up into its input queue.
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (pattern_left == 0) begin
          rx_pattern   = rx_pattern_t'($urandom_range(0, 2));
          pattern_left = $urandom_range(20, 120);
        end
        pattern_left--;
        case (rx_pattern)
          RX_STEADY:    out_ready <= 1'b1;
          RX_COIN_FLIP: out_ready <= 1'($urandom_range(0, 1));
          default:      out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function automatic sha1md_in_t make_item(logic [7:0] data, logic has, logic last);
    sha1md_in_t item;
    item.data_byte = data;
    item.has_byte  = has;
    item.is_last   = last;
    return item;
  endfunction

  // Offer one transaction and wait for the handshake. Call at a falling edge;
  // returns at the falling edge after the handshake with valid still high, so the following
  // call can present its item without lowering valid in between.
  task automatic send_item(input sha1md_in_t item);
    int unsigned gap;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sha1_absorb(item);
    if (item.has_byte || item.is_last) message_items++;
    else dropped_items++;
    if (item.is_last) messages_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted digest byte has come out.
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    while (digest_bytes_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Send one message of random bytes. The final byte rides on the end
  // transaction or the end comes as a separate byte-less transaction;
  // noise_pct percent of the time a dropped transaction is slipped in.
  task automatic send_message(input int unsigned len, input bit end_carries_byte,
                              input int unsigned noise_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                          (i == len - 1) && end_carries_byte));
    end
    if (len == 0 || !end_carries_byte)
      send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty messages: two lone end transactions with no byte.
  task automatic test_empty_message();
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'hFF, 1'b0, 1'b1));
  endtask

  // "abc", then the extreme byte values with the end on the byte and apart from it.
  task automatic test_short_messages();
    send_item(make_item(8'h61, 1'b1, 1'b0));
    send_item(make_item(8'h62, 1'b1, 1'b0));
    send_item(make_item(8'h63, 1'b1, 1'b1));
    send_item(make_item(8'h00, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b1, 1'b1));
  endtask

  // Byte-less, non-final transactions must leave the message untouched.
  task automatic test_dropped_items();
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    send_item(make_item(8'h5A, 1'b1, 1'b0));
    send_item(make_item(8'hFF, 1'b0, 1'b0));
    send_item(make_item(8'h3C, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b0));
    send_item(make_item(8'hC3, 1'b1, 1'b1));
  endtask

  // Hold the receiver off for a long stretch while messages keep coming,
  // so the block fills and stalls its input.
  task automatic test_receiver_hold_off();
    sender_gaps_on = 1'b0;
    stall_request  = 400;
    for (int m = 0; m < 4; m++) send_message($urandom_range(2, 5), 1'b1, 0);
  endtask

  // Let the block go fully idle between messages; the second one fills a
  // whole block and pads in a block of its own.
  task automatic test_idle_between_messages();
    sender_gaps_on = 1'b0;
    send_message(4, 1'b1, 0);
    wait_for_digests();
    send_message(64, 1'b0, 0);
    wait_for_digests();
  endtask

  // Random messages, mostly short; the first is forced onto the padding
  // edge, where the length field just fits or spills into a block of its own.
  task automatic test_random_messages();
    int unsigned start_items;
    int unsigned len;
    int unsigned msg_idx;
    start_items = message_items;
    msg_idx     = 0;
    while (message_items - start_items < RANDOM_ITEMS) begin
      if (msg_idx == 0) len = $urandom_range(55, 63);
      else len = $urandom_range(0, 12);
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      send_message(len, 1'($urandom_range(0, 1)), 12);
      msg_idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    sender_gaps_on = 1'b1;
    burst_left     = 0;
    stall_request  = 0;
    error_count    = 0;
    digest_bytes_checked = 0;
    message_items  = 0;
    dropped_items  = 0;
    messages_sent  = 0;
    input_stall_cycles = 0;
    sha1_restart();

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_message();
    test_short_messages();
    test_dropped_items();
    test_receiver_hold_off();
    test_idle_between_messages();
    test_random_messages();

    // Drain, then watch a while longer for stray output.
    wait_for_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (digest_bytes_due.size() != 0)
      report_failure($sformatf("%0d digest bytes never arrived", digest_bytes_due.size()));

    $display("Covered %0d messages from %0d transactions plus %0d dropped ones.",
             messages_sent, message_items, dropped_items);
    $display("Checked %0d digest bytes; input pushed back for %0d cycles; %0d errors.",
             digest_bytes_checked, input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
